// ===== design/ghd_pkg.sv =====
`timescale 1ns / 1ps

package ghd_pkg;

	// configuration register indexes
	localparam logic REG_GROUP_BYTES  = 1'b0;
	localparam logic REG_OUT_CAPACITY = 1'b1;

	localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_A     = 8'h41;
	localparam logic [7:0] NIBBLE_HI  = 8'hF0;
	localparam logic [7:0] NIBBLE_LO  = 8'h0F;

	// up to a space, two digits and the terminator per byte
	localparam int unsigned MAX_CHARS = 4;

	typedef struct packed {
		logic [7:0] ch;
		logic       run_last;
		logic       all_written;
	} ghd_char_t;

	typedef struct packed {
		ghd_char_t [MAX_CHARS-1:0] slot;
		logic [2:0]                count;
	} ghd_result_t;

	typedef struct packed {
		logic [7:0]  group_position;
		logic [15:0] chars_written;
		logic        truncated;
		logic        first_byte_pending;
	} ghd_state_t;

	localparam ghd_state_t STATE_RESET = '{
		group_position:     8'd0,
		chars_written:      16'd0,
		truncated:          1'b0,
		first_byte_pending: 1'b1
	};

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		if (n < 4'd10) begin
			hex_digit = CHAR_ZERO + {4'd0, n};
		end else begin
			hex_digit = CHAR_A + {4'd0, n} - 8'd10;
		end
	endfunction

endpackage

// ===== design/ghd_encode.sv =====
`timescale 1ns / 1ps

module ghd_encode (
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  logic [7:0]          group_bytes,
	input  logic [15:0]         out_capacity,
	input  ghd_pkg::ghd_state_t cur,
	output ghd_pkg::ghd_state_t nxt,
	output ghd_pkg::ghd_result_t res
);

	logic [15:0] limit;
	logic [15:0] cw;
	logic        tr;
	logic [2:0]  n;
	logic [2:0]  n_prev;
	logic [7:0]  hi_bits;
	logic [7:0]  lo_bits;

	assign limit   = (out_capacity == 16'd0) ? 16'd0 : out_capacity - 16'd1;
	assign hi_bits = (data_byte & ghd_pkg::NIBBLE_HI) >> 4;
	assign lo_bits = data_byte & ghd_pkg::NIBBLE_LO;

	always_comb begin
		res    = '0;
		nxt    = cur;
		cw     = cur.chars_written;
		tr     = cur.truncated;
		n      = 3'd0;
		n_prev = 3'd0;

		// high nibble, maybe after a group space
		if (tr || cw >= limit) begin
			tr = 1'b1;
		end else begin
			if (group_bytes != 8'd0 && !cur.first_byte_pending &&
					cur.group_position == 8'd0) begin
				res.slot[n[1:0]] = '{ch: ghd_pkg::CHAR_SPACE, run_last: 1'b0,
					all_written: 1'b0};
				n  = n + 3'd1;
				cw = cw + 16'd1;
			end
			if (cw >= limit) begin
				tr = 1'b1;
			end else begin
				res.slot[n[1:0]] = '{ch: ghd_pkg::hex_digit(hi_bits[3:0]),
					run_last: 1'b0, all_written: 1'b0};
				n  = n + 3'd1;
				cw = cw + 16'd1;
			end
		end

		// low nibble
		if (tr || cw >= limit) begin
			tr = 1'b1;
		end else begin
			res.slot[n[1:0]] = '{ch: ghd_pkg::hex_digit(lo_bits[3:0]),
				run_last: 1'b0, all_written: 1'b0};
			n  = n + 3'd1;
			cw = cw + 16'd1;
		end

		nxt.chars_written      = cw;
		nxt.truncated          = tr;
		nxt.first_byte_pending = 1'b0;
		if ({1'b0, cur.group_position} + 9'd1 >= {1'b0, group_bytes}) begin
			nxt.group_position = 8'd0;
		end else begin
			nxt.group_position = cur.group_position + 8'd1;
		end

		if (last_byte) begin
			res.slot[n[1:0]] = '{ch: ghd_pkg::CHAR_NUL, run_last: 1'b1,
				all_written: !tr};
			n   = n + 3'd1;
			nxt = ghd_pkg::STATE_RESET;
		end else if (n != 3'd0) begin
			n_prev = n - 3'd1;
			res.slot[n_prev[1:0]].run_last = 1'b1;
		end

		res.count = n;
	end

endmodule

// ===== design/grouped_hex_dump_encoder.sv =====
`timescale 1ns / 1ps

// channel   dir  tdata            tlast        tuser
// s_axis    in   data_byte[7:0]   last_byte    -
// m_axis    out  out_char[7:0]    run_last     all_written
// cfg       in   cfg_addr 0: group_bytes, 1: out_capacity (cfg_wdata[7:0] / [15:0])
//
// each byte is encoded in the cycle it is taken and parked as up to four characters;
// characters leave one per cycle through the output register unless m_tready holds
// them; a byte makes two or three characters typically, four with terminator, and
// none when the buffer is already full and it is not the last byte. a new byte is
// taken as soon as the parked characters are down to the one leaving.
// arst_n resets the block state, the config registers, the parked characters and the output valid flag.
// m_tready low simply holds the output register and the parked characters.

module grouped_hex_dump_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // data_byte
	input  logic        s_tlast,  // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // out_char
	output logic        m_tlast,  // run_last
	output logic        m_tuser   // all_written
);

	logic [7:0]           group_bytes_q;
	logic [15:0]          out_capacity_q;
	ghd_pkg::ghd_state_t  state_q;
	ghd_pkg::ghd_state_t  state_nxt;
	ghd_pkg::ghd_result_t enc_res;
	ghd_pkg::ghd_result_t park_s1;
	ghd_pkg::ghd_char_t   out_q;
	logic                 out_valid_q;
	logic                 take;
	logic                 pop;

	ghd_encode u_encode (
		.data_byte    (s_tdata),
		.last_byte    (s_tlast),
		.group_bytes  (group_bytes_q),
		.out_capacity (out_capacity_q),
		.cur          (state_q),
		.nxt          (state_nxt),
		.res          (enc_res)
	);

	assign pop      = (park_s1.count != 3'd0) && (!out_valid_q || m_tready);
	assign s_tready = (park_s1.count == 3'd0) || (park_s1.count == 3'd1 && pop);
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_bytes_q  <= 8'd0;
			out_capacity_q <= ghd_pkg::CAPACITY_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				ghd_pkg::REG_GROUP_BYTES:  group_bytes_q  <= cfg_wdata[7:0];
				ghd_pkg::REG_OUT_CAPACITY: out_capacity_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ghd_pkg::STATE_RESET;
		end else if (take) begin
			state_q <= state_nxt;
		end
	end

	// parked characters: a new transaction reloads, otherwise shift down on pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			park_s1 <= '0;
		end else if (take) begin
			park_s1 <= enc_res;
		end else if (pop) begin
			for (int i = 0; i < ghd_pkg::MAX_CHARS - 1; i++) begin
				park_s1.slot[i] <= park_s1.slot[i+1];
			end
			park_s1.slot[ghd_pkg::MAX_CHARS-1] <= '0;
			park_s1.count <= park_s1.count - 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= park_s1.slot[0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.ch;
	assign m_tlast  = out_q.run_last;
	assign m_tuser  = out_q.all_written;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

// expected characters of the hex dump, worked out per accepted byte
class hex_dump_scoreboard;
	ghd_pkg::ghd_char_t expected_chars[$];
	logic [7:0]         group_bytes;
	logic [15:0]        out_capacity;
	logic [7:0]         group_position;
	logic [15:0]        chars_written;
	logic               truncated;
	logic               first_byte_pending;
	int                 errors;
	string              digits;

	function new();
		digits         = "0123456789ABCDEF";
		errors         = 0;
		group_bytes    = 8'd0;
		out_capacity   = ghd_pkg::CAPACITY_RESET;
		clear_block();
	endfunction

	function void clear_block();
		group_position     = 8'd0;
		chars_written      = 16'd0;
		truncated          = 1'b0;
		first_byte_pending = 1'b1;
	endfunction

	function void write_reg(logic idx, logic [15:0] value);
		if (idx == ghd_pkg::REG_GROUP_BYTES) begin
			group_bytes = value[7:0];
		end else begin
			out_capacity = value;
		end
	endfunction

	function ghd_pkg::ghd_char_t make_char(logic [7:0] ch);
		ghd_pkg::ghd_char_t c;
		c.ch          = ch;
		c.run_last    = 1'b0;
		c.all_written = 1'b0;
		return c;
	endfunction

	function void encode_byte(logic [7:0] data, logic last);
		ghd_pkg::ghd_char_t chars[$];
		ghd_pkg::ghd_char_t term;
		logic [15:0]        limit;
		limit = (out_capacity == 16'd0) ? 16'd0 : out_capacity - 16'd1;

		// high nibble, with a leading space at the start of a group
		if (truncated || chars_written >= limit) begin
			truncated = 1'b1;
		end else begin
			if (group_bytes != 8'd0 && !first_byte_pending && group_position == 8'd0) begin
				chars.push_back(make_char(ghd_pkg::CHAR_SPACE));
				chars_written++;
			end
			if (chars_written >= limit) begin
				truncated = 1'b1;
			end else begin
				chars.push_back(make_char(8'(digits[data[7:4]])));
				chars_written++;
			end
		end

		if (truncated || chars_written >= limit) begin
			truncated = 1'b1;
		end else begin
			chars.push_back(make_char(8'(digits[data[3:0]])));
			chars_written++;
		end

		first_byte_pending = 1'b0;
		if (int'(group_position) + 1 >= int'(group_bytes)) begin
			group_position = 8'd0;
		end else begin
			group_position++;
		end

		if (last) begin
			term             = make_char(ghd_pkg::CHAR_NUL);
			term.run_last    = 1'b1;
			term.all_written = !truncated;
			chars.push_back(term);
			clear_block();
		end else if (chars.size() > 0) begin
			chars[chars.size() - 1].run_last = 1'b1;
		end

		foreach (chars[i]) expected_chars.push_back(chars[i]);
	endfunction

	function void check_char(logic [7:0] ch, logic run_last, logic all_written);
		ghd_pkg::ghd_char_t exp_c;
		if (expected_chars.size() == 0) begin
			$error("unexpected character %h with no expectation pending", ch);
			errors++;
			return;
		end
		exp_c = expected_chars.pop_front();
		if (ch !== exp_c.ch) begin
			$error("out_char: expected %h, actual %h", exp_c.ch, ch);
			errors++;
		end
		if (run_last !== exp_c.run_last) begin
			$error("run_last: expected %b, actual %b", exp_c.run_last, run_last);
			errors++;
		end
		if (all_written !== exp_c.all_written) begin
			$error("all_written: expected %b, actual %b", exp_c.all_written, all_written);
			errors++;
		end
	endfunction

	function int pending();
		return expected_chars.size();
	endfunction
endclass

module tb;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_addr  = ghd_pkg::REG_GROUP_BYTES;
	logic [15:0] cfg_wdata = 16'd0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'd0;
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	hex_dump_scoreboard sb;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	bit rx_hold_req  = 1'b0;
	int rx_hold_left = 0;

	grouped_hex_dump_encoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// output side: random back-pressure, long hold-off on request, transaction check
	always @(posedge clk) begin
		if (sb != null && m_tvalid && m_tready) begin
			sb.check_char(m_tdata, m_tlast, m_tuser);
		end
		if (rx_hold_req) begin
			rx_hold_req  = 1'b0;
			rx_hold_left = 120;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	task automatic send_byte(input logic [7:0] data, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		sb.encode_byte(data, last);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		// a byte with a full buffer makes no character, give it time to settle
		repeat (6) @(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] gb, input logic [15:0] cap);
		cfg_we    <= 1'b1;
		cfg_addr  <= ghd_pkg::REG_GROUP_BYTES;
		cfg_wdata <= {8'd0, gb};
		@(posedge clk);
		sb.write_reg(ghd_pkg::REG_GROUP_BYTES, {8'd0, gb});
		cfg_addr  <= ghd_pkg::REG_OUT_CAPACITY;
		cfg_wdata <= cap;
		@(posedge clk);
		sb.write_reg(ghd_pkg::REG_OUT_CAPACITY, cap);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [7:0]  gb;
		logic [15:0] cap;
		int          sent;
		int          phase;
		int          n;

		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: no grouping, large buffer, digit extremes
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h09, 1'b0);
		send_byte(8'h0A, 1'b1);
		wait_drained();

		// buffer fills mid-block, later bytes dropped, terminator reports it
		set_config(8'd2, 16'd8);
		send_byte(8'h01, 1'b0);
		send_byte(8'h23, 1'b0);
		send_byte(8'h45, 1'b0);
		send_byte(8'h67, 1'b0);
		send_byte(8'h89, 1'b1);
		wait_drained();

		// group space is the last character that fits
		set_config(8'd1, 16'd4);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b1);
		wait_drained();

		// exact fit
		set_config(8'd0, 16'd5);
		send_byte(8'hAB, 1'b0);
		send_byte(8'hCD, 1'b1);
		wait_drained();

		// zero capacity and capacity one: terminator only
		set_config(8'd0, 16'd0);
		send_byte(8'hFF, 1'b1);
		wait_drained();
		set_config(8'd255, 16'd1);
		send_byte(8'h7E, 1'b1);
		wait_drained();

		// group size shrinks in the middle of a block
		set_config(8'd4, 16'hFFFF);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h3C, 1'b0);
		wait_drained();
		set_config(8'd2, 16'hFFFF);
		send_byte(8'h5A, 1'b0);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h96, 1'b1);
		wait_drained();

		// capacity drops below what is already written
		set_config(8'd0, 16'hFFFF);
		send_byte(8'hE1, 1'b0);
		send_byte(8'h1E, 1'b0);
		send_byte(8'h88, 1'b0);
		wait_drained();
		set_config(8'd0, 16'd3);
		send_byte(8'h77, 1'b1);
		wait_drained();

		// random blocks; phases may end mid-block so settings change inside a block
		sent  = 0;
		phase = 0;
		while (sent < 385) begin
			if (sent < 128) begin
				src_idle_pct = 16;
				snk_idle_pct = 49;
			end else if (sent < 256) begin
				src_idle_pct = 49;
				snk_idle_pct = 16;
			end else begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			case ($urandom_range(7))
				0: gb = 8'd0;
				1: gb = 8'd1;
				2: gb = 8'd2;
				3: gb = 8'd3;
				4: gb = 8'd4;
				5: gb = 8'd8;
				6: gb = 8'($urandom_range(255));
				default: gb = 8'd255;
			endcase
			case ($urandom_range(6))
				0: cap = 16'd1;
				1: cap = 16'($urandom_range(2, 12));
				2: cap = 16'($urandom_range(10, 40));
				3: cap = 16'($urandom_range(10, 40));
				4: cap = 16'hFFFF;
				5: cap = 16'($urandom_range(65535));
				default: cap = 16'd2;
			endcase
			set_config(gb, cap);
			if (phase == 0) rx_hold_req = 1'b1;
			n = $urandom_range(10, 40);
			repeat (n) begin
				send_byte(8'($urandom_range(255)), ($urandom_range(6) == 0));
				sent++;
			end
			wait_drained();
			phase++;
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
design/ghd_pkg.sv
design/ghd_encode.sv
design/grouped_hex_dump_encoder.sv
tb/sv/tb.sv
